FILE: rtl/core/cdad_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date add days: shared package
// Widths, sequencer states and Gregorian calendar helpers for the date unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdad_pkg;

  localparam int unsigned MAX_YEAR = 9999;
  localparam int unsigned YR_W     = $clog2(MAX_YEAR + 1);

  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned OFF_W  = 17;
  localparam int unsigned T_W    = OFF_W + 1;
  localparam int unsigned RQ_W   = 9;

  localparam int unsigned IN_W  = DAY_W + MON_W + YEAR_W + OFF_W;
  localparam int unsigned OUT_W = ((DAY_W + MON_W + YEAR_W + 7) / 8) * 8;

  localparam int unsigned ERA_YEARS = 400;
  localparam int unsigned ZERO_YEAR = 2000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD400,
    ST_DOY,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  // Leap status from the year modulo 400.
  function automatic logic is_leap(input logic [RQ_W-1:0] r);
    is_leap = (r[1:0] == 2'd0) && (r != RQ_W'(100)) && (r != RQ_W'(200))
              && (r != RQ_W'(300));
  endfunction

  function automatic logic [8:0] year_days(input logic leap);
    year_days = leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    case (m)
      4'd2:    month_days = leap ? 5'd29 : 5'd28;
      4'd4:    month_days = 5'd30;
      4'd6:    month_days = 5'd30;
      4'd9:    month_days = 5'd30;
      4'd11:   month_days = 5'd30;
      default: month_days = 5'd31;
    endcase
  endfunction

  // Days of the year that lie before the first of month m.
  function automatic logic [8:0] days_before(input logic [MON_W-1:0] m,
                                             input logic leap);
    logic [8:0] base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    days_before = base + ((leap && (m > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/calendar_date_add_days_unit.sv
// ----------------------------------------------------------------------------
// Calendar date add days unit
// Adds a signed day offset to a Gregorian date by stepping years, then months.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Signals                  | Content
//  --------+-----+--------------------------+----------------------------------
//  s_axis  | in  | tvalid, tready, tdata    | start date and day offset
//  m_axis  | out | tvalid, tready, tdata,   | result date, saturation flag
//          |     | tuser                    |
//
//  One transfer is worked on at a time; the input is not ready until the
//  result has been taken. Each item runs through a reduction of the year
//  modulo 400, the day-of-year sum, one step per year crossed and one per
//  month step (at most 11); a single adder on the day count does all year
//  and month steps. Reset clears the sequencer only; a stalled result simply
//  holds.
`default_nettype none

module calendar_date_add_days_unit
  import cdad_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_day, start_month, start_year, day_offset
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // result_day, result_month, result_year, zero fill
  output logic [OUT_W-1:0]      m_axis_tdata,
  // out_of_range
  output logic                  m_axis_tuser
);

  state_e state_q, state_d;

  logic [DAY_W-1:0]        d_q, d_d;
  logic [MON_W-1:0]        m_q, m_d;
  logic [YR_W-1:0]         y_q, y_d;
  logic [YR_W-1:0]         r_q, r_d;
  logic signed [OFF_W-1:0] off_q, off_d;
  logic signed [T_W-1:0]   t_q, t_d;
  logic                    flag_q, flag_d;

  logic [DAY_W-1:0]        in_day;
  logic [MON_W-1:0]        in_mon;
  logic [YEAR_W-1:0]       in_year;
  logic [YR_W-1:0]         r_prev;
  logic                    lp, lp_prev;
  logic [8:0]              ylen;
  logic [DAY_W-1:0]        mlen;
  logic [DAY_W-1:0]        dval;
  logic [8:0]              doy;
  logic signed [T_W-1:0]   addend;
  logic signed [T_W-1:0]   sum;

  assign in_day  = s_axis_tdata[DAY_W-1:0];
  assign in_mon  = s_axis_tdata[DAY_W+MON_W-1:DAY_W];
  assign in_year = s_axis_tdata[DAY_W+MON_W+YEAR_W-1:DAY_W+MON_W];

  assign lp      = is_leap(r_q[RQ_W-1:0]);
  assign r_prev  = (r_q == YR_W'(0)) ? YR_W'(ERA_YEARS - 1) : r_q - YR_W'(1);
  assign lp_prev = is_leap(r_prev[RQ_W-1:0]);
  assign ylen    = year_days(lp);
  assign mlen    = month_days(m_q, lp);
  assign dval    = ((d_q == '0) || (d_q > mlen)) ? DAY_W'(1) : d_q;
  assign doy     = days_before(m_q, lp) + 9'(dval) - 9'd1;
  assign sum     = t_q + addend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= d_d;
    m_q    <= m_d;
    y_q    <= y_d;
    r_q    <= r_d;
    off_q  <= off_d;
    t_q    <= t_d;
    flag_q <= flag_d;
  end

  always_comb begin
    state_d = state_q;
    d_d     = d_q;
    m_d     = m_q;
    y_d     = y_q;
    r_d     = r_q;
    off_d   = off_q;
    t_d     = t_q;
    flag_d  = flag_q;
    addend  = '0;

    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_DONE);

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          d_d    = in_day;
          m_d    = ((in_mon == '0) || (in_mon > MON_W'(12))) ? MON_W'(1) : in_mon;
          if (in_year == '0) begin
            y_d = YR_W'(ZERO_YEAR);
          end else if (32'(in_year) > MAX_YEAR) begin
            y_d = YR_W'(MAX_YEAR);
          end else begin
            y_d = YR_W'(in_year);
          end
          r_d     = y_d;
          off_d   = s_axis_tdata[IN_W-1:IN_W-OFF_W];
          flag_d  = 1'b0;
          state_d = ST_MOD400;
        end
      end
      ST_MOD400: begin
        if (r_q >= YR_W'(ERA_YEARS)) begin
          r_d = r_q - YR_W'(ERA_YEARS);
        end else begin
          state_d = ST_DOY;
        end
      end
      ST_DOY: begin
        d_d     = dval;
        t_d     = T_W'($signed({1'b0, doy})) + T_W'(off_q);
        state_d = ST_YEAR;
      end
      ST_YEAR: begin
        if (t_q < 0) begin
          addend = T_W'($signed({1'b0, year_days(lp_prev)}));
          if (y_q == YR_W'(1)) begin
            d_d     = DAY_W'(1);
            m_d     = MON_W'(1);
            flag_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            y_d = y_q - YR_W'(1);
            r_d = r_prev;
            t_d = sum;
          end
        end else if (t_q >= T_W'($signed({1'b0, ylen}))) begin
          addend = -T_W'($signed({1'b0, ylen}));
          if (32'(y_q) >= MAX_YEAR) begin
            d_d     = DAY_W'(31);
            m_d     = MON_W'(12);
            flag_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            y_d = y_q + YR_W'(1);
            r_d = (r_q == YR_W'(ERA_YEARS - 1)) ? YR_W'(0) : r_q + YR_W'(1);
            t_d = sum;
          end
        end else begin
          m_d     = MON_W'(1);
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        addend = -T_W'($signed({1'b0, mlen}));
        if (t_q >= T_W'($signed({1'b0, mlen}))) begin
          t_d = sum;
          m_d = m_q + MON_W'(1);
        end else begin
          d_d     = t_q[DAY_W-1:0] + DAY_W'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tdata = OUT_W'({YEAR_W'(y_q), m_q, d_q});
  assign m_axis_tuser = flag_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("Input ready while a result is pending.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("Input still ready after a transfer was accepted.");

  a_month_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[8:5] != 4'd0) && (m_axis_tdata[8:5] <= 4'd12)))
    else $error("Result month out of range.");

  a_saturated_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata[4:0] == 5'd1) && (m_axis_tdata[8:5] == 4'd1)
       && (m_axis_tdata[22:9] == 14'd1))
      || ((m_axis_tdata[4:0] == 5'd31) && (m_axis_tdata[8:5] == 4'd12)
       && (m_axis_tdata[22:9] == YEAR_W'(MAX_YEAR))))
    else $error("Saturated result is not a limit date.");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_calendar_date_add_days_unit.sv
// ----------------------------------------------------------------------------
// Testbench: calendar date add days unit
// Sends start dates with signed day offsets over the input stream and
// checks every result date and saturation flag against an in-bench
// Gregorian calculator. The run covers directed corner cases and random
// traffic under several flow-control phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_calendar_date_add_days_unit;
  import cdad_pkg::*;

  localparam int unsigned N_PHASES       = 4;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned HOLD_CYCLES    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_start_t;

  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic              saturated;
  } date_result_t;

  class date_scoreboard;
    date_result_t expected_q[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  saturated;

    function new();
      errors    = 0;
      checked   = 0;
      saturated = 0;
    endfunction

    function bit leap(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function int unsigned month_length(int unsigned m, int unsigned y);
      case (m)
        2:           return leap(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    // Day count from 1 March of year 0, with the year starting in March.
    function longint day_number(longint y, longint m, longint d);
      longint yy, era, yoe, mm, doy, doe;
      yy  = y - ((m <= 2) ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mm  = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mm + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe;
    endfunction

    function void to_date(longint z, output int unsigned y, output int unsigned m,
                          output int unsigned d);
      longint era, doe, yoe, yy, doy, mp;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yy  = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      y   = (m <= 2) ? yy + 1 : yy;
    endfunction

    function date_result_t add_days(date_start_t s);
      int unsigned  y, m, d, ry, rm, rd;
      longint       z, first_day, last_day;
      date_result_t r;
      y = s.year;
      m = s.month;
      d = s.day;
      if (y == 0) y = ZERO_YEAR;
      if (y > MAX_YEAR) y = MAX_YEAR;
      if (m < 1 || m > 12) m = 1;
      if (d < 1 || d > month_length(m, y)) d = 1;
      first_day = day_number(1, 1, 1);
      last_day  = day_number(MAX_YEAR, 12, 31);
      z = day_number(y, m, d) + longint'($signed(s.offset));
      r.saturated = 1'b0;
      if (z < first_day) begin
        ry = 1;
        rm = 1;
        rd = 1;
        r.saturated = 1'b1;
      end else if (z > last_day) begin
        ry = MAX_YEAR;
        rm = 12;
        rd = 31;
        r.saturated = 1'b1;
      end else begin
        to_date(z, ry, rm, rd);
      end
      r.day   = rd[DAY_W-1:0];
      r.month = rm[MON_W-1:0];
      r.year  = ry[YEAR_W-1:0];
      return r;
    endfunction

    function void note_start(date_start_t s);
      expected_q.push_back(add_days(s));
    endfunction

    function void check_date(date_result_t got);
      date_result_t want;
      checked++;
      if (got.saturated) saturated++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no date pending: %0d-%0d-%0d flag %0b", $time,
                 got.year, got.month, got.day, got.saturated);
        return;
      end
      want = expected_q.pop_front();
      if (got.day !== want.day) begin
        errors++;
        $display("%0t: day expected %0d actual %0d", $time, want.day, got.day);
      end
      if (got.month !== want.month) begin
        errors++;
        $display("%0t: month expected %0d actual %0d", $time, want.month, got.month);
      end
      if (got.year !== want.year) begin
        errors++;
        $display("%0t: year expected %0d actual %0d", $time, want.year, got.year);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: out_of_range expected %0b actual %0b", $time, want.saturated,
                 got.saturated);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  logic              hold_armed = 1'b0;
  logic              hold_done = 1'b0;
  int unsigned       hold_left = 0;
  longint unsigned   cycle_count = 0;

  date_scoreboard    sb = new();

  calendar_date_add_days_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The long hold-off keeps a result pending while the sender keeps offering.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    date_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.day       = m_axis_tdata[DAY_W-1:0];
      got.month     = m_axis_tdata[DAY_W+MON_W-1:DAY_W];
      got.year      = m_axis_tdata[DAY_W+MON_W+YEAR_W-1:DAY_W+MON_W];
      got.saturated = m_axis_tuser;
      sb.check_date(got);
    end
  end

  function automatic date_start_t mk_start(int unsigned d, int unsigned m,
                                           int unsigned y, int off);
    date_start_t s;
    s.day    = d[DAY_W-1:0];
    s.month  = m[MON_W-1:0];
    s.year   = y[YEAR_W-1:0];
    s.offset = off[OFF_W-1:0];
    return s;
  endfunction

  function automatic date_start_t random_start();
    int unsigned kind, y, m, d;
    int          off;
    kind = $urandom_range(99);
    if (kind < 75) begin
      if (kind < 55) y = $urandom_range(1, MAX_YEAR);
      else if (kind < 65) y = $urandom_range(1, 200);
      else y = $urandom_range(MAX_YEAR - 200, MAX_YEAR);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, sb.month_length(m, y));
      if (kind < 30) off = $signed($urandom_range(800)) - 400;
      else off = $urandom_range(17'h1FFFF);
      return mk_start(d, m, y, off);
    end
    return mk_start($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                    $urandom_range(17'h1FFFF));
  endfunction

  task automatic send_start(date_start_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= s;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_start(s);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_start(mk_start(1, 1, 1, 0));
    send_start(mk_start(1, 1, 1, -1));
    send_start(mk_start(31, 12, 9999, 0));
    send_start(mk_start(31, 12, 9999, 1));
    send_start(mk_start(15, 6, 0, 0));
    send_start(mk_start(10, 3, 16383, -5));
    send_start(mk_start(5, 0, 2023, 10));
    send_start(mk_start(5, 13, 2023, 10));
    send_start(mk_start(5, 15, 2023, -10));
    send_start(mk_start(0, 7, 2023, 1));
    send_start(mk_start(31, 4, 2023, 0));
    send_start(mk_start(29, 2, 2001, 0));
    send_start(mk_start(29, 2, 2000, 1));
    send_start(mk_start(29, 2, 1900, 0));
    send_start(mk_start(29, 2, 2024, 365));
    send_start(mk_start(28, 2, 2100, 1));
    send_start(mk_start(31, 12, 1999, 1));
    send_start(mk_start(1, 3, 2000, -1));
    send_start(mk_start(1, 1, 2000, 65535));
    send_start(mk_start(1, 1, 2000, -65536));
    send_start(mk_start(31, 15, 16383, -65536));
    send_start(mk_start(1, 1, 9999, 65535));
    send_start(mk_start(1, 1, 100, -65536));
    send_start(mk_start(15, 8, 5000, -1));

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
          hold_armed     <= 1'b1;
        end
        1: begin
          send_idle_pct  <= 64;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 64;
        end
        default: begin
          send_idle_pct  <= 10;
          recv_stall_pct <= 10;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_start(random_start());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d result dates, %0d of them saturated at a year limit.",
             sb.checked, sb.saturated);
    $display("Traffic ran with and without gaps and stalls, plus one long output hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
